FILE: hdl/sog_pkg.sv
// sog_pkg: shared widths, mode codes, generator constants and the
// controller-to-datapath command and status types of the stagger order generator.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sog_pkg;

    // field widths
    localparam int CNT_W  = 7;
    localparam int MODE_W = 3;
    localparam int SEED_W = 32;
    localparam int POS_W  = 6;

    // order modes
    localparam logic [MODE_W-1:0] MODE_FIRST  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_LAST   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_CENTER = 3'd2;
    localparam logic [MODE_W-1:0] MODE_EDGES  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_RANDOM = 3'd4;

    // mulberry32 constants
    localparam logic [SEED_W-1:0] RNG_INC    = 32'h6d2b79f5;
    localparam logic [SEED_W-1:0] RNG_OR_ONE = 32'd1;
    localparam logic [SEED_W-1:0] RNG_OR_MIX = 32'd61;
    localparam int                RNG_SH_A   = 15;
    localparam int                RNG_SH_B   = 7;
    localparam int                RNG_SH_C   = 14;

    // datapath commands
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_FILL,
        OP_RNG_ADD,
        OP_RNG_MUL1,
        OP_RNG_MUL2,
        OP_RNG_MIX,
        OP_RNG_IDX,
        OP_SWAP_RD,
        OP_SWAP_WI,
        OP_SWAP_WJ,
        OP_INV_RD,
        OP_INV_WR,
        OP_OUT_RD,
        OP_OUT_LD
    } sog_op_t;

    // datapath status
    typedef struct packed {
        logic n_zero;
        logic n_one;
        logic random;
        logic at_last;
        logic ctr_one;
        logic out_free;
    } sog_status_t;

endpackage

`default_nettype wire

FILE: hdl/stagger_order_generator_unit.sv
// stagger_order_generator_unit: top level, joins sog_ctrl and sog_datapath.
// Depends on sog_pkg, sog_ctrl, sog_datapath.
//
//  channel  direction  ports                                         beat
//  s_       in         s_unit_count s_order_mode s_seed              one request
//  m_       out        m_unit_position m_step_number m_last_flag     one unit result
//
// a request is accepted and decoded; random mode then runs n fill writes and n - 1
// shuffle steps (4 generator stages, index multiply, swap read, two swap writes on
// the single store write port) and a read and a write per entry for inversion; every
// mode then gives a read and a load per result; n is the count after saturation, and
// a zero count ends after decode.
// reset is synchronous on aresetn low; store contents are left as they are.
// a stalled m_ready holds the sequencer at the next result; s_ready is low
// from an accepted request until its last beat is loaded into the output register.
`timescale 1ns / 1ps
`default_nettype none

module stagger_order_generator_unit
    import sog_pkg::*;
#(
    parameter int MAX_UNITS = 64
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [CNT_W-1:0]  s_unit_count,
    input  wire logic [MODE_W-1:0] s_order_mode,
    input  wire logic [SEED_W-1:0] s_seed,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [POS_W-1:0]       m_unit_position,
    output logic [POS_W-1:0]       m_step_number,
    output logic                   m_last_flag
);

    sog_op_t     op;
    sog_status_t status;

    // sequencer
    sog_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .op      (op)
    );

    // stores, generator and result register
    sog_datapath #(
        .MAX_UNITS (MAX_UNITS)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .op              (op),
        .status          (status),
        .s_unit_count    (s_unit_count),
        .s_order_mode    (s_order_mode),
        .s_seed          (s_seed),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_unit_position (m_unit_position),
        .m_step_number   (m_step_number),
        .m_last_flag     (m_last_flag)
    );

endmodule

`default_nettype wire

FILE: hdl/sog_datapath.sv
// sog_datapath: request registers, mulberry32 generator, shuffle and inverse
// stores, position counter and the result register.
// Depends on sog_pkg; driven by sog_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module sog_datapath
    import sog_pkg::*;
#(
    parameter int MAX_UNITS = 64
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire sog_op_t           op,
    output sog_status_t            status,
    input  wire logic [CNT_W-1:0]  s_unit_count,
    input  wire logic [MODE_W-1:0] s_order_mode,
    input  wire logic [SEED_W-1:0] s_seed,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [POS_W-1:0]       m_unit_position,
    output logic [POS_W-1:0]       m_step_number,
    output logic                   m_last_flag
);

    localparam int IDX_W = $clog2(MAX_UNITS);
    localparam int PRD_W = SEED_W + CNT_W;

    // control registers
    logic [CNT_W-1:0]  ctr_reg, ctr_next;
    logic [SEED_W-1:0] rng_reg, rng_next;
    logic              m_valid_reg, m_valid_next;

    // payload registers
    logic [CNT_W-1:0]  n_reg;
    logic [MODE_W-1:0] mode_reg;
    logic [SEED_W-1:0] mix_reg, mix2_reg, draw_reg;
    logic [IDX_W-1:0]  j_reg;
    logic [IDX_W-1:0]  rd_a_reg, rd_b_reg, inv_rd_reg;
    logic [POS_W-1:0]  pos_reg, step_reg;
    logic              last_reg;

    // stores
    logic [IDX_W-1:0]  sh_mem  [MAX_UNITS];
    logic [IDX_W-1:0]  inv_mem [MAX_UNITS];

    logic [CNT_W-1:0]  n_sat;
    logic [CNT_W-1:0]  last_idx;
    logic [IDX_W-1:0]  ctr_idx;
    logic              at_last;
    logic              out_free;

    logic [SEED_W-1:0] m1_a, m1_b, m2_a, m2_b, mix_e, draw_val;
    logic [63:0]       m1_full, m2_full;
    logic [PRD_W-1:0]  idx_prod;
    logic [CNT_W-1:0]  idx_hi, j_sel;

    logic [CNT_W-1:0]  step_rev, step_edge;
    logic [CNT_W:0]    dbl, lastx, cdiff;
    logic [CNT_W-1:0]  step_sel;

    logic              sh_we;
    logic [IDX_W-1:0]  sh_waddr, sh_wdata;

    // request decode and counters
    assign n_sat    = (s_unit_count > CNT_W'(MAX_UNITS)) ? CNT_W'(MAX_UNITS) : s_unit_count;
    assign last_idx = n_reg - CNT_W'(1);
    assign ctr_idx  = ctr_reg[IDX_W-1:0];
    assign at_last  = (ctr_reg == last_idx);
    assign out_free = !m_valid_reg || m_ready;

    assign status.n_zero   = (n_reg == '0);
    assign status.n_one    = (n_reg == CNT_W'(1));
    assign status.random   = (mode_reg == MODE_RANDOM);
    assign status.at_last  = at_last;
    assign status.ctr_one  = (ctr_reg == CNT_W'(1));
    assign status.out_free = out_free;

    // generator mixing, one multiplier per step
    assign m1_a     = rng_reg ^ (rng_reg >> RNG_SH_A);
    assign m1_b     = rng_reg | RNG_OR_ONE;
    assign m1_full  = 64'(m1_a) * 64'(m1_b);
    assign m2_a     = mix_reg ^ (mix_reg >> RNG_SH_B);
    assign m2_b     = mix_reg | RNG_OR_MIX;
    assign m2_full  = 64'(m2_a) * 64'(m2_b);
    assign mix_e    = mix_reg ^ (mix_reg + mix2_reg);
    assign draw_val = mix_e ^ (mix_e >> RNG_SH_C);

    // scaled draw picks the swap partner
    assign idx_prod = PRD_W'(draw_reg) * PRD_W'(CNT_W'(ctr_reg + CNT_W'(1)));
    assign idx_hi   = idx_prod[SEED_W +: CNT_W];
    assign j_sel    = (idx_hi > ctr_reg) ? ctr_reg : idx_hi;

    // step number per mode
    assign step_rev  = last_idx - ctr_reg;
    assign dbl       = {ctr_reg, 1'b0};
    assign lastx     = {1'b0, last_idx};
    assign cdiff     = (dbl >= lastx) ? (dbl - lastx) : (lastx - dbl);
    assign step_edge = (ctr_reg < step_rev) ? ctr_reg : step_rev;

    always_comb begin
        case (mode_reg)
            MODE_LAST:   step_sel = step_rev;
            MODE_CENTER: step_sel = cdiff[CNT_W:1];
            MODE_EDGES:  step_sel = step_edge;
            MODE_RANDOM: step_sel = CNT_W'(inv_rd_reg);
            default:     step_sel = ctr_reg;
        endcase
    end

    // next values of control registers
    always_comb begin
        ctr_next     = ctr_reg;
        rng_next     = rng_reg;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (op)
            OP_LOAD: begin
                ctr_next = '0;
                if (s_order_mode == MODE_RANDOM && n_sat != '0) begin
                    rng_next = s_seed;
                end
            end
            OP_FILL:    ctr_next = at_last ? last_idx : ctr_reg + CNT_W'(1);
            OP_RNG_ADD: rng_next = rng_reg + RNG_INC;
            OP_SWAP_WJ: ctr_next = ctr_reg - CNT_W'(1);
            OP_INV_WR:  ctr_next = at_last ? '0 : ctr_reg + CNT_W'(1);
            OP_OUT_LD: begin
                if (out_free) begin
                    ctr_next     = ctr_reg + CNT_W'(1);
                    m_valid_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctr_reg     <= '0;
            rng_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            ctr_reg     <= ctr_next;
            rng_reg     <= rng_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        case (op)
            OP_LOAD: begin
                n_reg    <= n_sat;
                mode_reg <= s_order_mode;
            end
            OP_RNG_MUL1: mix_reg  <= m1_full[SEED_W-1:0];
            OP_RNG_MUL2: mix2_reg <= m2_full[SEED_W-1:0];
            OP_RNG_MIX:  draw_reg <= draw_val;
            OP_RNG_IDX:  j_reg    <= j_sel[IDX_W-1:0];
            OP_OUT_LD: begin
                if (out_free) begin
                    pos_reg  <= ctr_reg[POS_W-1:0];
                    step_reg <= step_sel[POS_W-1:0];
                    last_reg <= at_last;
                end
            end
            default: ;
        endcase
    end

    // shuffle store write port
    always_comb begin
        sh_we    = 1'b0;
        sh_waddr = ctr_idx;
        sh_wdata = ctr_idx;
        case (op)
            OP_FILL: sh_we = 1'b1;
            OP_SWAP_WI: begin
                sh_we    = 1'b1;
                sh_wdata = rd_b_reg;
            end
            OP_SWAP_WJ: begin
                sh_we    = 1'b1;
                sh_waddr = j_reg;
                sh_wdata = rd_a_reg;
            end
            default: ;
        endcase
    end

    // shuffle store: one write, two registered reads
    always_ff @(posedge aclk) begin
        if (sh_we) begin
            sh_mem[sh_waddr] <= sh_wdata;
        end
        if (op == OP_SWAP_RD || op == OP_INV_RD) begin
            rd_a_reg <= sh_mem[ctr_idx];
        end
        if (op == OP_SWAP_RD) begin
            rd_b_reg <= sh_mem[j_reg];
        end
    end

    // inverse store
    always_ff @(posedge aclk) begin
        if (op == OP_INV_WR) begin
            inv_mem[rd_a_reg] <= ctr_idx;
        end
        if (op == OP_OUT_RD) begin
            inv_rd_reg <= inv_mem[ctr_idx];
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_unit_position = pos_reg;
    assign m_step_number   = step_reg;
    assign m_last_flag     = last_reg;

`ifndef SYNTHESIS
    // fill never runs past the request count
    a_fill_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (op == OP_FILL) |-> (ctr_reg < n_reg))
        else $error("fill beyond unit count");

    // swap partner never above the current shuffle position
    a_swap_partner: assert property (@(posedge aclk) disable iff (!aresetn)
        (op == OP_RNG_IDX) |=> (CNT_W'(j_reg) <= ctr_reg))
        else $error("swap partner out of range");

    // a waiting beat is never overwritten by a new load
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (op == OP_OUT_LD && m_valid_reg && !m_ready) |=>
            ($stable(pos_reg) && $stable(step_reg) && $stable(last_reg)))
        else $error("result overwritten while stalled");
`endif

endmodule

`default_nettype wire

FILE: hdl/sog_ctrl.sv
// sog_ctrl: state machine sequencing load, fill, shuffle, invert and output
// phases of the stagger order generator.
// Depends on sog_pkg; commands sog_datapath.
`timescale 1ns / 1ps
`default_nettype none

module sog_ctrl
    import sog_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire sog_status_t status,
    output sog_op_t          op
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_FILL,
        ST_RNG_ADD,
        ST_RNG_MUL1,
        ST_RNG_MUL2,
        ST_RNG_MIX,
        ST_RNG_IDX,
        ST_SWAP_RD,
        ST_SWAP_WI,
        ST_SWAP_WJ,
        ST_INV_RD,
        ST_INV_WR,
        ST_OUT_RD,
        ST_OUT_LD
    } state_t;

    state_t state_reg, state_next;
    logic   s_ready_reg, s_ready_next;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:     if (s_valid) state_next = ST_START;
            ST_START: begin
                if (status.n_zero) begin
                    state_next = ST_IDLE;
                end else if (status.random) begin
                    state_next = ST_FILL;
                end else begin
                    state_next = ST_OUT_RD;
                end
            end
            ST_FILL: begin
                if (status.at_last) begin
                    state_next = status.n_one ? ST_INV_RD : ST_RNG_ADD;
                end
            end
            ST_RNG_ADD:  state_next = ST_RNG_MUL1;
            ST_RNG_MUL1: state_next = ST_RNG_MUL2;
            ST_RNG_MUL2: state_next = ST_RNG_MIX;
            ST_RNG_MIX:  state_next = ST_RNG_IDX;
            ST_RNG_IDX:  state_next = ST_SWAP_RD;
            ST_SWAP_RD:  state_next = ST_SWAP_WI;
            ST_SWAP_WI:  state_next = ST_SWAP_WJ;
            ST_SWAP_WJ:  state_next = status.ctr_one ? ST_INV_RD : ST_RNG_ADD;
            ST_INV_RD:   state_next = ST_INV_WR;
            ST_INV_WR:   state_next = status.at_last ? ST_OUT_RD : ST_INV_RD;
            ST_OUT_RD:   state_next = ST_OUT_LD;
            ST_OUT_LD: begin
                if (status.out_free) begin
                    state_next = status.at_last ? ST_IDLE : ST_OUT_RD;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    assign s_ready_next = (state_next == ST_IDLE);

    // command decode
    always_comb begin
        case (state_reg)
            ST_IDLE:     op = s_valid ? OP_LOAD : OP_NONE;
            ST_FILL:     op = OP_FILL;
            ST_RNG_ADD:  op = OP_RNG_ADD;
            ST_RNG_MUL1: op = OP_RNG_MUL1;
            ST_RNG_MUL2: op = OP_RNG_MUL2;
            ST_RNG_MIX:  op = OP_RNG_MIX;
            ST_RNG_IDX:  op = OP_RNG_IDX;
            ST_SWAP_RD:  op = OP_SWAP_RD;
            ST_SWAP_WI:  op = OP_SWAP_WI;
            ST_SWAP_WJ:  op = OP_SWAP_WJ;
            ST_INV_RD:   op = OP_INV_RD;
            ST_INV_WR:   op = OP_INV_WR;
            ST_OUT_RD:   op = OP_OUT_RD;
            ST_OUT_LD:   op = OP_OUT_LD;
            default:     op = OP_NONE;
        endcase
    end

    // state and registered ready
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            s_ready_reg <= 1'b1;
        end else begin
            state_reg   <= state_next;
            s_ready_reg <= s_ready_next;
        end
    end

    assign s_ready = s_ready_reg;

`ifndef SYNTHESIS
    // one request at a time: ready drops right after an accepted beat
    a_ready_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready_reg) |=> !s_ready_reg)
        else $error("ready held after accept");
`endif

endmodule

`default_nettype wire

FILE: bench/testbench.sv
// testbench: self-checking bench for stagger_order_generator_unit, request and result streams
// with random idling on both sides, checked beat by beat against an in-bench step predictor.
// Depends on sog_pkg and stagger_order_generator_unit.
`timescale 1ns / 1ps

module testbench
    import sog_pkg::*;
;

    localparam int MAX_UNITS   = 64;
    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 30;
    localparam int RANDOM_REQS = 406;

    typedef struct {
        logic [POS_W-1:0] pos;
        logic [POS_W-1:0] step;
        logic             last;
    } unit_result_t;

    // step predictor and store of expected unit results
    class step_order_board;
        unit_result_t      expected_q[$];
        logic [SEED_W-1:0] gen_state;
        int                mismatches;

        function new();
            gen_state  = '0;
            mismatches = 0;
        endfunction

        // one mulberry32 draw, advancing the generator
        function logic [SEED_W-1:0] next_draw();
            logic [SEED_W-1:0] e;
            gen_state = gen_state + RNG_INC;
            e = gen_state;
            e = (e ^ (e >> RNG_SH_A)) * (e | RNG_OR_ONE);
            e = e ^ (e + ((e ^ (e >> RNG_SH_B)) * (e | RNG_OR_MIX)));
            return e ^ (e >> RNG_SH_C);
        endfunction

        // work out the results of one accepted request
        function void note_request(input logic [CNT_W-1:0] cnt, input logic [MODE_W-1:0] mode,
                                   input logic [SEED_W-1:0] seed);
            int               n;
            int               j;
            int               spread;
            logic [POS_W-1:0] perm[64];
            logic [POS_W-1:0] rank[64];
            logic [POS_W-1:0] tmp;
            logic [63:0]      prod;
            unit_result_t     res;
            n = (int'(cnt) > MAX_UNITS) ? MAX_UNITS : int'(cnt);
            if (n == 0)
                return;
            // shuffle, then invert the permutation
            if (mode == MODE_RANDOM) begin
                gen_state = seed;
                for (int k = 0; k < n; k++)
                    perm[k] = POS_W'(k);
                for (int i = n - 1; i > 0; i--) begin
                    prod = {32'd0, next_draw()} * 64'(i + 1);
                    j = int'(prod >> 32);
                    tmp = perm[i];
                    perm[i] = perm[j];
                    perm[j] = tmp;
                end
                for (int k = 0; k < n; k++)
                    rank[perm[k]] = POS_W'(k);
            end
            for (int i = 0; i < n; i++) begin
                res.pos  = POS_W'(i);
                res.last = (i == n - 1);
                case (mode)
                    MODE_LAST: begin
                        res.step = POS_W'(n - 1 - i);
                    end
                    MODE_CENTER: begin
                        spread = 2 * i - (n - 1);
                        if (spread < 0)
                            spread = -spread;
                        res.step = POS_W'(spread >> 1);
                    end
                    MODE_EDGES: begin
                        res.step = POS_W'((i < n - 1 - i) ? i : n - 1 - i);
                    end
                    MODE_RANDOM: begin
                        res.step = rank[i];
                    end
                    default: begin
                        res.step = POS_W'(i);
                    end
                endcase
                expected_q.push_back(res);
            end
        endfunction

        task log_mismatch(input string msg);
            if (mismatches < 40)
                $display("ERROR %0t: %s", $realtime, msg);
            mismatches++;
        endtask

        // compare one result beat with the oldest expectation
        task check_result(input logic [POS_W-1:0] pos, input logic [POS_W-1:0] step,
                          input logic last);
            unit_result_t want;
            if (expected_q.size() == 0) begin
                log_mismatch($sformatf("unexpected beat pos=%0d step=%0d last=%0b",
                                       pos, step, last));
                return;
            end
            want = expected_q.pop_front();
            if (pos !== want.pos || step !== want.step || last !== want.last)
                log_mismatch($sformatf("got pos=%0d step=%0d last=%0b, want pos=%0d step=%0d last=%0b",
                                       pos, step, last, want.pos, want.step, want.last));
        endtask

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [CNT_W-1:0]  s_unit_count = '0;
    logic [MODE_W-1:0] s_order_mode = '0;
    logic [SEED_W-1:0] s_seed = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [POS_W-1:0]  m_unit_position;
    logic [POS_W-1:0]  m_step_number;
    logic              m_last_flag;

    logic              steady = 1'b0;
    int                quiet_cycles = 0;
    step_order_board   board;

    stagger_order_generator_unit #(
        .MAX_UNITS (MAX_UNITS)
    ) DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_unit_count    (s_unit_count),
        .s_order_mode    (s_order_mode),
        .s_seed          (s_seed),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_unit_position (m_unit_position),
        .m_step_number   (m_step_number),
        .m_last_flag     (m_last_flag)
    );

    always #2 aclk = ~aclk;

    // result side: check accepted beats, stall at random
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            board.check_result(m_unit_position, m_step_number, m_last_flag);
        m_ready <= steady || ($urandom_range(99) >= 27);
    end

    // watchdog on cycles with no beat on either channel
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("stagger_order_generator_unit verification failed");
                $finish;
            end
        end
    end

    // present one request, with an occasional gap ahead of it
    task automatic send_request(input logic [CNT_W-1:0] cnt, input logic [MODE_W-1:0] mode,
                                input logic [SEED_W-1:0] seed);
        if (!steady && $urandom_range(99) < 27) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_unit_count <= cnt;
        s_order_mode <= mode;
        s_seed       <= seed;
        do @(posedge aclk); while (!s_ready);
        board.note_request(cnt, mode, seed);
    endtask

    // random request, mostly small counts so random mode stays quick
    task automatic send_random_request();
        int                r;
        logic [CNT_W-1:0]  cnt;
        logic [MODE_W-1:0] mode;
        logic [SEED_W-1:0] seed;
        r = $urandom_range(99);
        if (r < 5)
            cnt = '0;
        else if (r < 65)
            cnt = CNT_W'($urandom_range(1, 12));
        else if (r < 85)
            cnt = CNT_W'($urandom_range(13, 40));
        else if (r < 93)
            cnt = CNT_W'($urandom_range(41, MAX_UNITS));
        else
            cnt = CNT_W'($urandom_range(MAX_UNITS + 1, 127));
        mode = ($urandom_range(99) < 40) ? MODE_RANDOM : MODE_W'($urandom_range(7));
        r = $urandom_range(9);
        seed = (r == 0) ? '0 : (r == 1) ? '1 : $urandom;
        send_request(cnt, mode, seed);
    endtask

    initial begin
        board = new();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: single unit and full size in every mode code, zero count,
        // saturation, tiny center and edge cases
        for (int md = 0; md < 8; md++)
            send_request(CNT_W'(1), MODE_W'(md), '0);
        for (int md = 0; md < 8; md++)
            send_request(CNT_W'(MAX_UNITS), MODE_W'(md), '1);
        send_request('0, MODE_FIRST, '0);
        send_request('0, MODE_RANDOM, 32'h1234_5678);
        send_request(CNT_W'(2), MODE_CENTER, '0);
        send_request(CNT_W'(2), MODE_EDGES, '0);
        send_request(CNT_W'(65), MODE_LAST, '0);
        send_request('1, MODE_RANDOM, '1);
        send_request(CNT_W'(5), MODE_EDGES, '0);
        send_request(CNT_W'(6), MODE_CENTER, '0);

        // random requests, with a stretch of no idling on either side
        for (int k = 0; k < RANDOM_REQS; k++) begin
            steady <= (k >= 150 && k < 260);
            send_random_request();
        end
        s_valid <= 1'b0;
        steady  <= 1'b0;

        while (board.pending() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (board.mismatches == 0)
            $display("stagger_order_generator_unit verification clean");
        else
            $display("stagger_order_generator_unit verification failed");
        $finish;
    end

endmodule
